@@ design/pidhb_pkg.sv @@
`timescale 1ns / 1ps

package pidhb_pkg;

    localparam int ANGLE_W = 16;
    localparam int ERR_W   = ANGLE_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int SUM_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 16;
    localparam int CFG_IDX_W = 2;

    // shared multiplier: unsigned A operand times signed B operand
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = SUM_W + 1;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

    localparam int ACC_W   = 51;
    localparam int DRIVE_W = 7;
    localparam int DRIVE_MAX = 100;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^23
    localparam int SCALED_W    = 23;
    localparam int RECIP_SHIFT = 30;
    localparam logic [MUL_A_W-1:0] RECIP_100 = 24'd10737419;

    typedef enum logic [1:0] {
        CFG_GAIN_PROP  = 2'd0,
        CFG_GAIN_INTEG = 2'd1,
        CFG_GAIN_DERIV = 2'd2,
        CFG_PWM_TOP    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_CLAMP,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

@@ design/pidhb_mul.sv @@
`timescale 1ns / 1ps

module pidhb_mul (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [pidhb_pkg::MUL_A_W-1:0]         op_a,
    input  logic signed [pidhb_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [pidhb_pkg::PROD_W-1:0]   prod
);
    import pidhb_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= $signed({1'b0, op_a}) * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

@@ design/pid_position_hbridge_drive.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata: setpoint, measured_angle
// m_        out        m_tvalid / m_tready  m_tdata: duty_right, duty_left
// cfg_      in         cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
// Each word steps through PREP, MUL_P, MUL_I, MUL_D, ACC, CLAMP, SCALE, DIV and
// DONE. The single 25x33 multiplier is used five times in sequence (three
// gains, pwm_top scaling, divide by 100), and a new word is taken only in IDLE.
// Synchronous active-low reset clears the gains to their defaults and the
// integral and previous-error state. A stalled result holds the sequencer in
// its last step; s_tready is low until the word is handed on.

module pid_position_hbridge_drive (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,   // setpoint, measured_angle
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata,   // duty_right, duty_left
    input  logic                                  cfg_wr_en,
    input  logic [pidhb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidhb_pkg::GAIN_W-1:0]          cfg_wdata
);
    import pidhb_pkg::*;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg, pwm_top_reg;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [SUM_W-1:0]  err_sum_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DRIVE_W-1:0]       drive_reg;

    logic                     m_tvalid_reg;
    logic [DUTY_W-1:0]        duty_right_reg, duty_left_reg;

    logic                     mul_en;
    logic [MUL_A_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [ACC_W-8:0]  acc_neg;
    logic signed [ACC_W-8:0]  drive_raw;
    logic [DRIVE_W-1:0]       drive_clamped;
    logic [DUTY_W-1:0]        quot;
    logic                     load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {duty_left_reg, duty_right_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= GAIN_W'(256);
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            pwm_top_reg    <= GAIN_W'(1023);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_PROP:  gain_prop_reg  <= cfg_wdata;
                CFG_GAIN_INTEG: gain_integ_reg <= cfg_wdata;
                CFG_GAIN_DERIV: gain_deriv_reg <= cfg_wdata;
                CFG_PWM_TOP:    pwm_top_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturating integral
    always_comb begin
        sum_wide = {err_sum_reg[SUM_W-1], err_sum_reg} + (SUM_W+1)'(err_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // floor(acc / 256), steered by error sign, clamped to 0..100
    always_comb begin
        acc_neg   = -$signed({acc_reg[ACC_W-1], acc_reg[ACC_W-1:8]});
        drive_raw = err_reg[ERR_W-1] ? acc_neg
                                     : $signed({acc_reg[ACC_W-1], acc_reg[ACC_W-1:8]});
        if (drive_raw[ACC_W-8]) begin
            drive_clamped = '0;
        end else if (drive_raw > (ACC_W-7)'(DRIVE_MAX)) begin
            drive_clamped = DRIVE_W'(DRIVE_MAX);
        end else begin
            drive_clamped = drive_raw[DRIVE_W-1:0];
        end
    end

    assign quot = prod[RECIP_SHIFT +: DUTY_W];

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_P: begin
                mul_a = MUL_A_W'(gain_prop_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            ST_MUL_I: begin
                mul_a = MUL_A_W'(gain_integ_reg);
                mul_b = MUL_B_W'(err_sum_reg);
            end
            ST_MUL_D: begin
                mul_a = MUL_A_W'(gain_deriv_reg);
                mul_b = MUL_B_W'(diff_reg);
            end
            ST_SCALE: begin
                mul_a = MUL_A_W'(pwm_top_reg);
                mul_b = $signed({{(MUL_B_W-DRIVE_W){1'b0}}, drive_reg});
            end
            ST_DIV: begin
                mul_a = RECIP_100;
                mul_b = $signed({{(MUL_B_W-SCALED_W){1'b0}}, prod[SCALED_W-1:0]});
            end
            default: mul_en = 1'b0;
        endcase
    end

    pidhb_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign load_out = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_ACC;
            ST_ACC:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
        end else if (state_reg == ST_PREP) begin
            prev_err_reg <= err_reg;
            err_sum_reg  <= sum_sat;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                err_reg <= ERR_W'($signed(s_tdata[15:0])) - ERR_W'($signed(s_tdata[31:16]));
            end
            ST_PREP: begin
                diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
            end
            ST_MUL_P: acc_reg <= '0;
            ST_MUL_I, ST_MUL_D, ST_ACC: acc_reg <= acc_reg + prod[ACC_W-1:0];
            ST_CLAMP: drive_reg <= drive_clamped;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            duty_right_reg <= (!err_reg[ERR_W-1] && err_reg != '0) ? quot : '0;
            duty_left_reg  <= err_reg[ERR_W-1] ? quot : '0;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted word did not start the sequence");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (duty_right_reg == '0 || duty_left_reg == '0))
        else $error("both bridge sides driven");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |-> (drive_reg <= DRIVE_W'(DRIVE_MAX)))
        else $error("drive above full scale");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(duty_right_reg) && $stable(duty_left_reg))
        else $error("pending result overwritten");

endmodule
